### hw/rtl/thumb16_instruction_decoder_macros.svh
// Assertion macros for the thumb16 decoder.
`ifndef THUMB16_INSTRUCTION_DECODER_MACROS_SVH
`define THUMB16_INSTRUCTION_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define THB_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("thumb16 decoder check failed");
`define THB_ASSERT_DLY(label, clk, rst_n, a, n, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
		else $error("thumb16 decoder latency check failed");
`else
`define THB_ASSERT_IMP(label, clk, rst_n, a, c)
`define THB_ASSERT_DLY(label, clk, rst_n, a, n, c)
`endif

`endif

### hw/rtl/thb16_pkg.sv
package thb16_pkg;

	localparam logic [3:0] FORM_SHIFT   = 4'd0;
	localparam logic [3:0] FORM_ADDSUB  = 4'd1;
	localparam logic [3:0] FORM_IMM8    = 4'd2;
	localparam logic [3:0] FORM_ALU     = 4'd3;
	localparam logic [3:0] FORM_HIREG   = 4'd4;
	localparam logic [3:0] FORM_LDRLIT  = 4'd5;
	localparam logic [3:0] FORM_BCOND   = 4'd6;
	localparam logic [3:0] FORM_SVC     = 4'd7;
	localparam logic [3:0] FORM_BKPT    = 4'd8;
	localparam logic [3:0] FORM_HINT    = 4'd9;
	localparam logic [3:0] FORM_B       = 4'd10;
	localparam logic [3:0] FORM_BL      = 4'd11;
	localparam logic [3:0] FORM_LDST    = 4'd12;
	localparam logic [3:0] FORM_PUSHPOP = 4'd13;
	localparam logic [3:0] FORM_UNKNOWN = 4'd14;

	localparam logic [1:0] LEN_SHORT = 2'd1;
	localparam logic [1:0] LEN_LONG  = 2'd2;

	localparam logic [15:0] MASK_E000 = 16'hE000;
	localparam logic [15:0] MASK_1800 = 16'h1800;
	localparam logic [15:0] MASK_F800 = 16'hF800;
	localparam logic [15:0] MASK_FC00 = 16'hFC00;
	localparam logic [15:0] MASK_F000 = 16'hF000;
	localparam logic [15:0] MASK_FF00 = 16'hFF00;
	localparam logic [15:0] MASK_FF0F = 16'hFF0F;
	localparam logic [15:0] MASK_FE00 = 16'hFE00;
	localparam logic [15:0] MASK_D000 = 16'hD000;

	typedef struct packed {
		logic [3:0]  form;
		logic [3:0]  operation;
		logic [3:0]  dest_reg;
		logic [3:0]  src_reg;
		logic [2:0]  third_reg;
		logic [9:0]  immediate;
		logic        is_branch;
		logic [1:0]  halfwords_used;
		logic [31:0] offset;
		logic [31:0] pc_plus4;
	} dec_t;

endpackage

### hw/rtl/thb16_decode_stage.sv
module thb16_decode_stage
	import thb16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	input  logic [31:0] pc,
	input  logic [15:0] op,
	input  logic [15:0] nx,
	output logic        valid_s2,
	output dec_t        dec_s2
);

	dec_t dec;
	logic s_bit;
	logic i1;
	logic i2;

	always_comb begin
		s_bit = op[10];
		i1 = ~(nx[13] ^ s_bit);
		i2 = ~(nx[11] ^ s_bit);

		dec = '0;
		dec.form = FORM_UNKNOWN;
		dec.halfwords_used = LEN_SHORT;
		dec.pc_plus4 = pc + 32'd4;

		if ((op & MASK_E000) == 16'h0000 && (op & MASK_1800) != MASK_1800) begin
			dec.form = FORM_SHIFT;
			dec.operation = {2'b00, op[12:11]};
			dec.dest_reg = {1'b0, op[2:0]};
			dec.src_reg = {1'b0, op[5:3]};
			dec.immediate = {5'd0, op[10:6]};
		end else if ((op & MASK_F800) == 16'h1800) begin
			dec.form = FORM_ADDSUB;
			dec.operation = {2'b00, op[10:9]};
			dec.dest_reg = {1'b0, op[2:0]};
			dec.src_reg = {1'b0, op[5:3]};
			dec.third_reg = op[8:6];
		end else if ((op & MASK_E000) == 16'h2000) begin
			dec.form = FORM_IMM8;
			dec.operation = {2'b00, op[12:11]};
			dec.dest_reg = {1'b0, op[10:8]};
			dec.immediate = {2'b00, op[7:0]};
		end else if ((op & MASK_FC00) == 16'h4000) begin
			dec.form = FORM_ALU;
			dec.operation = op[9:6];
			dec.dest_reg = {1'b0, op[2:0]};
			dec.src_reg = {1'b0, op[5:3]};
		end else if ((op & MASK_FC00) == 16'h4400) begin
			dec.form = FORM_HIREG;
			dec.operation = {2'b00, op[9:8]};
			dec.dest_reg = {op[7], op[2:0]};
			dec.src_reg = op[6:3];
		end else if ((op & MASK_F800) == 16'h4800) begin
			dec.form = FORM_LDRLIT;
			dec.dest_reg = {1'b0, op[10:8]};
			dec.immediate = {op[7:0], 2'b00};
		end else if ((op & MASK_F000) == 16'hD000 && op[11:8] < 4'd14) begin
			dec.form = FORM_BCOND;
			dec.operation = op[11:8];
			dec.is_branch = 1'b1;
			dec.offset = {{23{op[7]}}, op[7:0], 1'b0};
		end else if ((op & MASK_FF00) == 16'hDF00) begin
			dec.form = FORM_SVC;
			dec.immediate = {2'b00, op[7:0]};
		end else if ((op & MASK_FF00) == 16'hBE00) begin
			dec.form = FORM_BKPT;
			dec.immediate = {2'b00, op[7:0]};
		end else if ((op & MASK_FF0F) == 16'hBF00) begin
			dec.form = FORM_HINT;
			dec.operation = op[7:4];
		end else if ((op & MASK_F800) == 16'hE000) begin
			dec.form = FORM_B;
			dec.is_branch = 1'b1;
			dec.offset = {{20{op[10]}}, op[10:0], 1'b0};
		end else if ((op & MASK_F800) == 16'hF000 && (nx & MASK_D000) == MASK_D000) begin
			dec.form = FORM_BL;
			dec.is_branch = 1'b1;
			dec.halfwords_used = LEN_LONG;
			dec.offset = {{7{s_bit}}, s_bit, i1, i2, op[9:0], nx[10:0], 1'b0};
		end else if ((op & MASK_E000) == 16'h6000) begin
			dec.form = FORM_LDST;
			dec.operation = {2'b00, op[12:11]};
			dec.dest_reg = {1'b0, op[2:0]};
			dec.src_reg = {1'b0, op[5:3]};
			dec.immediate = op[12] ? {5'd0, op[10:6]} : {3'd0, op[10:6], 2'b00};
		end else if ((op & MASK_FE00) == 16'hB400 || (op & MASK_FE00) == 16'hBC00) begin
			dec.form = FORM_PUSHPOP;
			dec.operation = {3'b000, op[11]};
			dec.immediate = {1'b0, op[8:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		dec_s2 <= dec;
	end

endmodule

### hw/rtl/thb16_target_stage.sv
module thb16_target_stage
	import thb16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	input  dec_t        dec,
	output logic        valid_s3,
	output logic [3:0]  form_s3,
	output logic [3:0]  operation_s3,
	output logic [3:0]  dest_reg_s3,
	output logic [3:0]  src_reg_s3,
	output logic [2:0]  third_reg_s3,
	output logic [9:0]  immediate_s3,
	output logic [31:0] target_s3,
	output logic [1:0]  halfwords_s3
);

	logic [31:0] target;

	assign target = dec.is_branch ? (dec.pc_plus4 + dec.offset) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		form_s3      <= dec.form;
		operation_s3 <= dec.operation;
		dest_reg_s3  <= dec.dest_reg;
		src_reg_s3   <= dec.src_reg;
		third_reg_s3 <= dec.third_reg;
		immediate_s3 <= dec.immediate;
		target_s3    <= target;
		halfwords_s3 <= dec.halfwords_used;
	end

endmodule

### hw/rtl/thumb16_instruction_decoder.sv
// start is carried to the done strobe through the registers valid_s1, valid_s2 and valid_s3.
// Throughput: one word per cycle; busy stays low, the receiver cannot stall.
// Stages: input register, class decode with PC+4, branch target add.
// Reset: arst_n low clears the stage valid bits at once; no word in flight
// survives reset.
`include "thumb16_instruction_decoder_macros.svh"

module thumb16_instruction_decoder
	import thb16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [31:0] program_counter,
	input  logic [15:0] first_halfword,
	input  logic [15:0] second_halfword,
	output logic [3:0]  form,
	output logic [3:0]  operation,
	output logic [3:0]  dest_reg,
	output logic [3:0]  src_reg,
	output logic [2:0]  third_reg,
	output logic [9:0]  immediate,
	output logic [31:0] branch_target,
	output logic [1:0]  halfwords_used
);

	logic        valid_s1;
	logic [31:0] pc_s1;
	logic [15:0] op_s1;
	logic [15:0] nx_s1;
	logic        valid_s2;
	dec_t        dec_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		pc_s1 <= program_counter;
		op_s1 <= first_halfword;
		nx_s1 <= second_halfword;
	end

	thb16_decode_stage u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s1),
		.pc       (pc_s1),
		.op       (op_s1),
		.nx       (nx_s1),
		.valid_s2 (valid_s2),
		.dec_s2   (dec_s2)
	);

	thb16_target_stage u_target (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s2),
		.dec          (dec_s2),
		.valid_s3     (done),
		.form_s3      (form),
		.operation_s3 (operation),
		.dest_reg_s3  (dest_reg),
		.src_reg_s3   (src_reg),
		.third_reg_s3 (third_reg),
		.immediate_s3 (immediate),
		.target_s3    (branch_target),
		.halfwords_s3 (halfwords_used)
	);

	`THB_ASSERT_DLY(a_latency, clk, arst_n, start && !busy, 3, done)
	`THB_ASSERT_IMP(a_no_spurious, clk, arst_n, done, $past(start, 3))
	`THB_ASSERT_IMP(a_bl_len, clk, arst_n, done && form == FORM_BL, halfwords_used == LEN_LONG)
	`THB_ASSERT_IMP(a_len_bl, clk, arst_n, done && halfwords_used != LEN_SHORT, form == FORM_BL)

endmodule
